// ----- rtl/tfcm_pkg.sv -----
package tfcm_pkg;
	localparam int TableRows = 26;
	localparam int DefTableSegments = 26;
	localparam logic [15:0] TableFloor = 16'd8462;
	localparam logic [1:0] SampleBytesOne = 2'd1;

	localparam logic [2:0] CfgSampleBytes = 3'd0;
	localparam logic [2:0] CfgLinearize = 3'd1;
	localparam logic [2:0] CfgColorMode = 3'd2;
	localparam logic [2:0] CfgWindowLow = 3'd3;
	localparam logic [2:0] CfgWindowSpan = 3'd4;

	function automatic logic [15:0] seg_upper(input logic [4:0] s);
		case (s)
			5'd0: seg_upper = 16'd8667;   5'd1: seg_upper = 16'd8878;
			5'd2: seg_upper = 16'd9095;   5'd3: seg_upper = 16'd9318;
			5'd4: seg_upper = 16'd9548;   5'd5: seg_upper = 16'd9784;
			5'd6: seg_upper = 16'd10027;  5'd7: seg_upper = 16'd10276;
			5'd8: seg_upper = 16'd10533;  5'd9: seg_upper = 16'd10797;
			5'd10: seg_upper = 16'd11068; 5'd11: seg_upper = 16'd11346;
			5'd12: seg_upper = 16'd11632; 5'd13: seg_upper = 16'd11926;
			5'd14: seg_upper = 16'd12227; 5'd15: seg_upper = 16'd12537;
			5'd16: seg_upper = 16'd12854; 5'd17: seg_upper = 16'd13180;
			5'd18: seg_upper = 16'd13514; 5'd19: seg_upper = 16'd13857;
			5'd20: seg_upper = 16'd14208; 5'd21: seg_upper = 16'd14569;
			5'd22: seg_upper = 16'd14938; 5'd23: seg_upper = 16'd15317;
			5'd24: seg_upper = 16'd15705; 5'd25: seg_upper = 16'd16103;
			default: seg_upper = 16'hFFFF;
		endcase
	endfunction

	function automatic logic [8:0] seg_slope(input logic [4:0] s);
		case (s)
			5'd0: seg_slope = 9'd205;  5'd1: seg_slope = 9'd211;
			5'd2: seg_slope = 9'd217;  5'd3: seg_slope = 9'd223;
			5'd4: seg_slope = 9'd230;  5'd5: seg_slope = 9'd236;
			5'd6: seg_slope = 9'd243;  5'd7: seg_slope = 9'd249;
			5'd8: seg_slope = 9'd257;  5'd9: seg_slope = 9'd264;
			5'd10: seg_slope = 9'd271; 5'd11: seg_slope = 9'd278;
			5'd12: seg_slope = 9'd286; 5'd13: seg_slope = 9'd294;
			5'd14: seg_slope = 9'd301; 5'd15: seg_slope = 9'd310;
			5'd16: seg_slope = 9'd317; 5'd17: seg_slope = 9'd326;
			5'd18: seg_slope = 9'd334; 5'd19: seg_slope = 9'd343;
			5'd20: seg_slope = 9'd351; 5'd21: seg_slope = 9'd361;
			5'd22: seg_slope = 9'd369; 5'd23: seg_slope = 9'd379;
			5'd24: seg_slope = 9'd388; 5'd25: seg_slope = 9'd398;
			default: seg_slope = 9'd1;
		endcase
	endfunction

	// floor(2^24/slope)+1, exact for 100*offset/slope over every segment
	function automatic logic [16:0] seg_recip(input logic [4:0] s);
		case (s)
			5'd0: seg_recip = 17'd81841;  5'd1: seg_recip = 17'd79513;
			5'd2: seg_recip = 17'd77315;  5'd3: seg_recip = 17'd75235;
			5'd4: seg_recip = 17'd72945;  5'd5: seg_recip = 17'd71090;
			5'd6: seg_recip = 17'd69043;  5'd7: seg_recip = 17'd67379;
			5'd8: seg_recip = 17'd65281;  5'd9: seg_recip = 17'd63551;
			5'd10: seg_recip = 17'd61909; 5'd11: seg_recip = 17'd60350;
			5'd12: seg_recip = 17'd58662; 5'd13: seg_recip = 17'd57066;
			5'd14: seg_recip = 17'd55739; 5'd15: seg_recip = 17'd54121;
			5'd16: seg_recip = 17'd52925; 5'd17: seg_recip = 17'd51464;
			5'd18: seg_recip = 17'd50232; 5'd19: seg_recip = 17'd48914;
			5'd20: seg_recip = 17'd47799; 5'd21: seg_recip = 17'd46475;
			5'd22: seg_recip = 17'd45467; 5'd23: seg_recip = 17'd44268;
			5'd24: seg_recip = 17'd43241; 5'd25: seg_recip = 17'd42154;
			default: seg_recip = 17'd0;
		endcase
	endfunction
endpackage

// ----- rtl/thermal_false_color_mapper_unit.sv -----
// Throughput: one transaction per clock; all stages advance together and stall
// together on output backpressure.
// Reset: arst_n asynchronously clears pipeline valid bits and restores
// configuration defaults.
module thermal_false_color_mapper_unit
	import tfcm_pkg::*;
#(
	parameter int TABLE_SEGMENTS = DefTableSegments
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // sample
	input  logic        s_tlast,  // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // red, green, blue, level, converted_value, range_flag, pad
	output logic        m_tlast   // frame_end_out
);
	localparam int Nseg = (TABLE_SEGMENTS > TableRows) ? TableRows : TABLE_SEGMENTS;
	localparam int Depth = 17;

	logic [1:0] sample_bytes_q;
	logic linearize_q, color_q;
	logic [15:0] wlow_q, wspan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q <= 2'd2;
			linearize_q <= 1'b1;
			color_q <= 1'b0;
			wlow_q <= '0;
			wspan_q <= 16'd4399;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgSampleBytes: sample_bytes_q <= cfg_data[1:0];
				CfgLinearize: linearize_q <= cfg_data[0];
				CfgColorMode: color_q <= cfg_data[0];
				CfgWindowLow: wlow_q <= cfg_data;
				CfgWindowSpan: wspan_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [Depth-1:0] vld_q;
	logic [Depth-1:0] last_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[Depth-1];
	assign m_tlast = last_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], s_tvalid};
	end
	always_ff @(posedge clk) begin
		if (en) last_q <= {last_q[Depth-2:0], s_tlast};
	end

	// s1: clamp, segment search
	logic [15:0] x_c;
	logic [4:0] seg_c;
	logic hit_c;
	always_comb begin
		x_c = (sample_bytes_q == SampleBytesOne) ? {8'd0, s_tdata[7:0]} : s_tdata;
		if (x_c < TableFloor) x_c = TableFloor;
		seg_c = '0;
		hit_c = 1'b0;
		for (int s = Nseg - 1; s >= 0; s--) begin
			if (x_c < seg_upper(5'(s))) begin
				seg_c = 5'(s);
				hit_c = 1'b1;
			end
		end
	end
	logic [15:0] raw_s1, x_s1;
	logic [4:0] seg_s1;
	logic hit_s1, below_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= (sample_bytes_q == SampleBytesOne) ? {8'd0, s_tdata[7:0]} : s_tdata;
			x_s1 <= x_c;
			seg_s1 <= seg_c;
			hit_s1 <= hit_c;
			below_s1 <= ((sample_bytes_q == SampleBytesOne) ? {8'd0, s_tdata[7:0]} : s_tdata)
				< TableFloor;
		end
	end

	// s2: offset*100
	logic [15:0] lower_c;
	assign lower_c = (seg_s1 == 5'd0) ? TableFloor : seg_upper(seg_s1 - 5'd1);
	logic [15:0] raw_s2, off_s2;
	logic [4:0] seg_s2;
	logic hit_s2, below_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			raw_s2 <= raw_s1;
			off_s2 <= 16'(32'(x_s1 - lower_c) * 32'd100);
			seg_s2 <= seg_s1;
			hit_s2 <= hit_s1;
			below_s2 <= below_s1;
		end
	end

	// s3: reciprocal multiply
	logic [15:0] raw_s3;
	logic [32:0] prod_s3;
	logic [4:0] seg_s3;
	logic hit_s3, below_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			raw_s3 <= raw_s2;
			prod_s3 <= 33'(off_s2) * 33'(seg_recip(seg_s2));
			seg_s3 <= seg_s2;
			hit_s3 <= hit_s2;
			below_s3 <= below_s2;
		end
	end

	// s4: value, window subtract
	logic [15:0] val_c;
	logic flag_c;
	always_comb begin
		if (!linearize_q) begin
			val_c = raw_s3;
			flag_c = 1'b0;
		end else if (!hit_s3) begin
			val_c = '0;
			flag_c = 1'b1;
		end else begin
			val_c = 16'(32'(seg_s3) * 32'd100 + 32'd1800 + 32'(prod_s3[31:24]));
			flag_c = below_s3;
		end
	end
	logic [15:0] val_s4, diff_s4, span_s4;
	logic neg_s4, flag_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			val_s4 <= val_c;
			diff_s4 <= val_c - wlow_q;
			neg_s4 <= val_c < wlow_q;
			flag_s4 <= flag_c;
			span_s4 <= (wspan_q == 16'd0) ? 16'd1 : wspan_q;
		end
	end

	// s5..s14: divider
	logic [8:0] quo;
	logic big;
	tfcm_divider #(.Stages(9)) u_div (
		.clk(clk), .en(en),
		.num(24'({8'd0, diff_s4} * 24'd255)), .den(span_s4),
		.quo(quo), .big(big)
	);
	logic [15:0] val_d [10];
	logic neg_d [10];
	logic flag_d [10];
	always_ff @(posedge clk) begin
		if (en) begin
			val_d[0] <= val_s4; neg_d[0] <= neg_s4; flag_d[0] <= flag_s4;
			for (int i = 1; i < 10; i++) begin
				val_d[i] <= val_d[i-1]; neg_d[i] <= neg_d[i-1]; flag_d[i] <= flag_d[i-1];
			end
		end
	end

	// s15: level
	logic [7:0] lvl_s15;
	logic [15:0] val_s15;
	logic flag_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			val_s15 <= val_d[9];
			if (neg_d[9]) begin
				lvl_s15 <= '0; flag_s15 <= 1'b1;
			end else if (big || quo[8]) begin
				lvl_s15 <= 8'd255; flag_s15 <= 1'b1;
			end else begin
				lvl_s15 <= quo[7:0]; flag_s15 <= flag_d[9];
			end
		end
	end

	// s16: stage and remainder
	logic [2:0] stg_c;
	logic [5:0] rem_c;
	always_comb begin
		if (lvl_s15 >= 8'd252) begin stg_c = 3'd4; rem_c = 6'(lvl_s15 - 8'd252); end
		else if (lvl_s15 >= 8'd189) begin stg_c = 3'd3; rem_c = 6'(lvl_s15 - 8'd189); end
		else if (lvl_s15 >= 8'd126) begin stg_c = 3'd2; rem_c = 6'(lvl_s15 - 8'd126); end
		else if (lvl_s15 >= 8'd63) begin stg_c = 3'd1; rem_c = 6'(lvl_s15 - 8'd63); end
		else begin stg_c = 3'd0; rem_c = 6'(lvl_s15); end
	end
	logic [7:0] lvl_s16;
	logic [15:0] val_s16;
	logic flag_s16;
	logic [2:0] stg_s16;
	logic [7:0] frac_s16;
	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s16 <= lvl_s15; val_s16 <= val_s15; flag_s16 <= flag_s15;
			stg_s16 <= stg_c;
			// rem*255/63 as rem*255*ceil(2^21/63) >> 21
			frac_s16 <= 8'((30'(rem_c) * 30'd8488695) >> 21);
		end
	end

	// s17: palette
	logic [7:0] r_c, g_c, b_c;
	always_comb begin
		if (!color_q) begin
			r_c = lvl_s16; g_c = lvl_s16; b_c = lvl_s16;
		end else begin
			case (stg_s16)
				3'd0: begin r_c = 8'd255; g_c = frac_s16; b_c = 8'd0; end
				3'd1: begin r_c = 8'd255 - frac_s16; g_c = 8'd255; b_c = 8'd0; end
				3'd2: begin r_c = 8'd0; g_c = 8'd255; b_c = frac_s16; end
				3'd3: begin r_c = 8'd0; g_c = 8'd255 - frac_s16; b_c = 8'd255; end
				default: begin r_c = 8'd0; g_c = 8'd0; b_c = 8'd255; end
			endcase
		end
	end
	logic [55:0] out_s17;
	always_ff @(posedge clk) begin
		if (en) out_s17 <= {7'd0, flag_s16, val_s16, lvl_s16, b_c, g_c, r_c};
	end
	assign m_tdata = out_s17;
endmodule

// ----- rtl/tfcm_divider.sv -----
// Restoring divider, one quotient bit per stage; numerator 24 bits, quotient clipped at 9 bits.
module tfcm_divider
	import tfcm_pkg::*;
#(
	parameter int Stages = 9
) (
	input  logic        clk,
	input  logic        en,
	input  logic [23:0] num,
	input  logic [15:0] den,
	output logic [Stages-1:0] quo,
	output logic        big
);
	// quotient >= 2^Stages check, registered together with the operands in the input register
	logic [23:0] num_p [Stages+1];
	logic [15:0] den_p [Stages+1];
	logic [Stages-1:0] q_p [Stages+1];
	logic big_p [Stages+1];
	logic [24:0] rem_p [Stages+1];

	always_ff @(posedge clk) begin
		if (en) begin
			num_p[0] <= num;
			den_p[0] <= den;
			big_p[0] <= (num >> Stages) >= 24'(den);
		end
	end
	assign rem_p[0] = 25'(num_p[0] >> Stages);
	assign q_p[0] = '0;

	for (genvar i = 0; i < Stages; i++) begin : g_st
		logic [24:0] r;
		logic [24:0] t;
		always_comb begin
			r = {rem_p[i][23:0], num_p[i][Stages-1-i]};
			t = r - 25'(den_p[i]);
		end
		logic [24:0] rem_r;
		logic [Stages-1:0] q_r;
		always_ff @(posedge clk) begin
			if (en) begin
				num_p[i+1] <= num_p[i];
				den_p[i+1] <= den_p[i];
				big_p[i+1] <= big_p[i];
				rem_r <= t[24] ? r : t;
				q_r <= {q_p[i][Stages-2:0], ~t[24]};
			end
		end
		assign rem_p[i+1] = rem_r;
		assign q_p[i+1] = q_r;
	end
	assign quo = q_p[Stages];
	assign big = big_p[Stages];
endmodule
